/* rtl/sscw_pkg.sv */
// Shared types, constants and font table for the seven segment chain writer.
package sscw_pkg;

  localparam int unsigned MAX_CHAIN = 8;
  localparam int unsigned CHAIN_W = 4;
  localparam int unsigned IDX_W = $clog2(MAX_CHAIN);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_REG = 1'b1;

  localparam logic [3:0] INTENSITY_ADDR = 4'hA;
  localparam logic [7:0] INTENSITY_MASK = 8'h0F;
  localparam logic [7:0] DP_BIT = 8'h80;
  localparam logic [15:0] NOOP_WORD = 16'h0000;

  typedef struct packed {
    logic [15:0]        word;
    logic [CHAIN_W-1:0] dev;
    logic [CHAIN_W-1:0] chain;
  } entry_t;

  function automatic logic [7:0] font_segs(input logic [7:0] c);
    logic [7:0] s;
    unique case (c)
      8'h20: s = 8'h00;
      8'h30: s = 8'h7e;
      8'h31: s = 8'h30;
      8'h32: s = 8'h6d;
      8'h33: s = 8'h79;
      8'h34: s = 8'h33;
      8'h35: s = 8'h5b;
      8'h36: s = 8'h5f;
      8'h37: s = 8'h70;
      8'h38: s = 8'h7f;
      8'h39: s = 8'h7b;
      8'h41: s = 8'h77;
      8'h42: s = 8'h1f;
      8'h43: s = 8'h4e;
      8'h44: s = 8'h3d;
      8'h45: s = 8'h4f;
      8'h46: s = 8'h47;
      8'h47: s = 8'h5f;
      8'h48: s = 8'h37;
      8'h49: s = 8'h30;
      8'h4a: s = 8'h4e;
      8'h4c: s = 8'h0e;
      8'h6e: s = 8'h15;
      8'h4f: s = 8'h7e;
      8'h50: s = 8'h67;
      8'h72: s = 8'h05;
      8'h53: s = 8'h5b;
      8'h54: s = 8'h46;
      8'h55: s = 8'h3e;
      8'h2d: s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/sscw_if.sv */
// Request and chain word channel interfaces.
interface sscw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] position;
  logic [7:0] ascii_code;
  logic       decimal_point;
  logic [3:0] device;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;

  modport source (output valid, req_type, position, ascii_code, decimal_point,
                  device, reg_addr, reg_data, input ready);
  modport sink (input valid, req_type, position, ascii_code, decimal_point,
                device, reg_addr, reg_data, output ready);
endinterface

interface sscw_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_word;
  logic        last_word;

  modport source (output valid, frame_word, last_word, input ready);
  modport sink (input valid, frame_word, last_word, output ready);
endinterface

/* rtl/sscw_front.sv */
// Front end: accepts requests, resolves target device and word, drops misses.
module sscw_front (
  sscw_req_if.sink                  req_i,
  input  logic [3:0]                chain_length_i,
  input  logic                      queue_full_i,
  output logic                      push_o,
  output sscw_pkg::entry_t          entry_o
);
  import sscw_pkg::*;

  logic [CHAIN_W-1:0] chain;
  logic [CHAIN_W-1:0] dev;
  logic [3:0]         addr;
  logic [7:0]         data;
  logic               drop;

  always_comb begin
    if (chain_length_i > CHAIN_W'(MAX_CHAIN)) begin
      chain = CHAIN_W'(MAX_CHAIN);
    end else begin
      chain = chain_length_i;
    end
  end

  always_comb begin
    unique case (req_i.req_type)
      REQ_CHAR: begin
        dev  = {1'b0, req_i.position[5:3]} + 4'd1;
        addr = 4'd8 - {1'b0, req_i.position[2:0]};
        data = font_segs(req_i.ascii_code) | (req_i.decimal_point ? DP_BIT : 8'h00);
      end
      default: begin
        dev  = req_i.device;
        addr = req_i.reg_addr;
        data = (req_i.reg_addr == INTENSITY_ADDR) ? (req_i.reg_data & INTENSITY_MASK)
                                                  : req_i.reg_data;
      end
    endcase
  end

  assign drop = (dev == '0) || (dev > chain);

  assign req_i.ready   = !queue_full_i;
  assign push_o        = req_i.valid && !queue_full_i && !drop;
  assign entry_o.word  = {4'h0, addr, data};
  assign entry_o.dev   = dev;
  assign entry_o.chain = chain;

endmodule

/* rtl/sscw_queue.sv */
// Short queue of resolved requests between front and back ends.
module sscw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sscw_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output sscw_pkg::entry_t head_o
);
  import sscw_pkg::*;

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/sscw_back.sv */
// Back end: expands the head request into one chain word per device.
module sscw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sscw_pkg::entry_t head_i,
  output logic             pop_o,
  sscw_word_if.source      word_o
);
  import sscw_pkg::*;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               valid_q, valid_d;
  logic [15:0]        word_q, word_d;
  logic               last_q, last_d;
  logic               load;
  logic               at_last;
  logic               at_target;
  logic [CHAIN_W-1:0] target;

  assign load      = !valid_q || word_o.ready;
  assign target    = head_i.chain - head_i.dev;
  assign at_last   = ({1'b0, idx_q} == (head_i.chain - 4'd1));
  assign at_target = ({1'b0, idx_q} == target);
  assign pop_o     = load && !empty_i && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    word_d  = word_q;
    last_d  = last_q;
    if (load) begin
      valid_d = !empty_i;
      word_d  = at_target ? head_i.word : NOOP_WORD;
      last_d  = at_last;
      if (!empty_i) begin
        idx_d = at_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign word_o.valid      = valid_q;
  assign word_o.frame_word = word_q;
  assign word_o.last_word  = last_q;

endmodule

/* rtl/seven_segment_chain_writer.sv */
// Top level of the seven segment chain writer.
// Each accepted request becomes one 16-bit word per chained chip (chain length
// capped at 8), sent farthest chip first, with last_word set on the final word.
// Requests for a chip beyond the chain produce no words. The back end sends one
// word per cycle unless word_o.ready holds it off; the front end accepts one
// request per cycle while the two-entry queue has room.
// chain_length resets to 1 and is written through cfg_we_i and cfg_wdata_i.
module seven_segment_chain_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  sscw_req_if.sink    req_i,
  sscw_word_if.source word_o
);
  import sscw_pkg::*;

  logic [3:0] chain_length_q;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  entry_t     entry;
  entry_t     head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_length_q <= 4'd1;
    end else if (cfg_we_i) begin
      chain_length_q <= cfg_wdata_i;
    end
  end

  sscw_front u_front (
    .req_i          (req_i),
    .chain_length_i (chain_length_q),
    .queue_full_i   (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  sscw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  sscw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .word_o  (word_o)
  );

endmodule
